// File: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types and constants: command codes, segment numbers, config defaults.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Command codes as carried in the action field
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_ACK   = 3'd5
   } cmd_type;

   // Configuration register indexes
   localparam logic CSR_UNIT_TICKS = 1'b0;
   localparam logic CSR_ACK_WAIT   = 1'b1;

   localparam int unsigned CSR_DATA_W = 10;

   localparam logic [9:0] UNIT_TICKS_RESET = 10'd48;
   localparam logic [7:0] ACK_WAIT_RESET   = 8'd200;

   // Segment numbers; zero means no command in progress
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_FIRST = 3'd1;

   localparam logic [7:0] MSB_MASK = 8'h80;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // One classified item handed from the front to the engine
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       nack_bit;
      logic       sda_line;
   } item_type;

   // Timing configuration seen by the engine
   typedef struct packed {
      logic [9:0] unit_ticks;
      logic [7:0] ack_wait_units;
   } cfg_type;

endpackage

// File: sv/i2cm_if.sv
// ----------------------------------------------------------------------------
// I2C master bit engine channels
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] tx_byte;
   logic       nack_bit;
   logic       sda_line;

   modport source (output valid, action, tx_byte, nack_bit, sda_line, input ready);
   modport sink   (input valid, action, tx_byte, nack_bit, sda_line, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_release;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       nack_seen;

   modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                   nack_seen, input ready);
   modport sink   (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                   nack_seen, output ready);
endinterface

// File: sv/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts request beats, decodes the action and queues items for the engine.
// ----------------------------------------------------------------------------
module i2cm_front #(
   parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   i2cm_req_if.sink           req_chan,
   output logic               head_valid,
   output i2cm_pkg::item_type head_item,
   input  logic               head_pop
);
   import i2cm_pkg::*;

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   item_type        q_mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   item_type        new_item;
   logic            push;
   logic            pop;

   // Decode the action; codes with no meaning become no command
   always_comb begin
      new_item.tx_byte  = req_chan.tx_byte;
      new_item.nack_bit = req_chan.nack_bit;
      new_item.sda_line = req_chan.sda_line;
      unique case (req_chan.action)
         3'd1:    new_item.cmd = CMD_START;
         3'd2:    new_item.cmd = CMD_STOP;
         3'd3:    new_item.cmd = CMD_WRITE;
         3'd4:    new_item.cmd = CMD_READ;
         3'd5:    new_item.cmd = CMD_ACK;
         default: new_item.cmd = CMD_NONE;
      endcase
   end

   assign req_chan.ready = (count_ff < CW'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = head_pop && (count_ff != '0);
   assign head_valid     = (count_ff != '0);
   assign head_item      = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

endmodule

// File: sv/i2cm_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine core
// Steps the segment timer and waveform sequencer once per queued item.
// ----------------------------------------------------------------------------
module i2cm_engine (
   input  logic               clock,
   input  logic               reset,
   input  i2cm_pkg::cfg_type  cfg,
   input  logic               head_valid,
   input  i2cm_pkg::item_type head_item,
   output logic               head_pop,
   i2cm_rsp_if.source         rsp_chan
);
   import i2cm_pkg::*;

   // Sequencer state
   logic [2:0] phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [9:0] tick_ff, tick_in;
   logic [7:0] unit_ff, unit_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       ack_ff, ack_in;
   cmd_type    cmd_ff, cmd_in;
   logic [7:0] rx_ff, rx_in;

   // Output register
   logic       rsp_valid_ff;
   logic       done_ff;
   logic       busy_ff;
   logic       done_in;

   logic       step;
   logic       enter;
   logic [2:0] enter_ph;
   logic [2:0] last_ph;
   logic [7:0] seg_units;
   logic [9:0] tick_reload;
   logic [7:0] ack_units;

   assign step     = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign head_pop = step;

   assign tick_reload = (cfg.unit_ticks == '0) ? 10'd0 : cfg.unit_ticks - 10'd1;
   assign ack_units   = (cfg.ack_wait_units == '0) ? 8'd1 : cfg.ack_wait_units;

   always_comb begin
      unique case (cmd_ff)
         CMD_START: last_ph = 3'd4;
         CMD_WRITE: last_ph = 3'd7;
         CMD_READ:  last_ph = 3'd5;
         default:   last_ph = 3'd3;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      tick_in   = tick_ff;
      unit_in   = unit_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      ack_in    = ack_ff;
      cmd_in    = cmd_ff;
      rx_in     = rx_ff;
      done_in   = 1'b0;
      enter     = 1'b0;
      enter_ph  = PH_IDLE;
      seg_units = 8'd1;

      if (phase_ff == PH_IDLE) begin
         if (head_item.cmd != CMD_NONE) begin
            cmd_in = head_item.cmd;
            bit_in = '0;
            unique case (head_item.cmd)
               CMD_WRITE: shift_in = head_item.tx_byte;
               CMD_ACK:   shift_in = {7'd0, head_item.nack_bit};
               default:   shift_in = '0;
            endcase
            enter    = 1'b1;
            enter_ph = PH_FIRST;
         end
      end else if (tick_ff != '0) begin
         tick_in = tick_ff - 10'd1;
      end else if (unit_ff != '0) begin
         unit_in = unit_ff - 8'd1;
         tick_in = tick_reload;
      end else if (cmd_ff == CMD_WRITE && phase_ff == 3'd3) begin
         // advance to the next data bit or on to the ACK slot
         shift_in = {shift_ff[6:0], 1'b0};
         bit_in   = bit_ff + 4'd1;
         enter    = 1'b1;
         enter_ph = bit_in[3] ? 3'd4 : 3'd1;
      end else if (cmd_ff == CMD_READ && phase_ff == 3'd4) begin
         bit_in = bit_ff + 4'd1;
         enter  = 1'b1;
         if (bit_in[3]) begin
            rx_in    = shift_ff;
            enter_ph = 3'd5;
         end else begin
            enter_ph = 3'd1;
         end
      end else begin
         if (cmd_ff == CMD_WRITE && phase_ff == 3'd6) begin
            ack_in = head_item.sda_line;
         end
         if (cmd_ff == CMD_READ && phase_ff == 3'd3) begin
            shift_in = {shift_ff[6:0], head_item.sda_line};
         end
         if (phase_ff >= last_ph) begin
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end else begin
            enter    = 1'b1;
            enter_ph = phase_ff + 3'd1;
         end
      end

      // Enter a segment: set line levels and load the timer
      if (enter) begin
         phase_in = enter_ph;
         unique case (cmd_in)
            CMD_START: begin
               if (enter_ph == 3'd1) begin
                  sda_in = 1'b1; seg_units = 8'd1;
               end else if (enter_ph == 3'd2) begin
                  scl_in = 1'b1; seg_units = 8'd5;
               end else if (enter_ph == 3'd3) begin
                  sda_in = 1'b0; seg_units = 8'd5;
               end else begin
                  scl_in = 1'b0; seg_units = 8'd2;
               end
            end
            CMD_STOP: begin
               if (enter_ph == 3'd1) begin
                  scl_in = 1'b0; sda_in = 1'b0; seg_units = 8'd1;
               end else if (enter_ph == 3'd2) begin
                  scl_in = 1'b1; seg_units = 8'd5;
               end else begin
                  sda_in = 1'b1; seg_units = 8'd5;
               end
            end
            CMD_ACK: begin
               if (enter_ph == 3'd1) begin
                  scl_in = 1'b0; sda_in = shift_in[0]; seg_units = 8'd3;
               end else if (enter_ph == 3'd2) begin
                  scl_in = 1'b1; seg_units = 8'd5;
               end else begin
                  scl_in = 1'b0; seg_units = 8'd2;
               end
            end
            CMD_WRITE: begin
               if (enter_ph == 3'd1) begin
                  scl_in = 1'b0; sda_in = |(shift_in & MSB_MASK); seg_units = 8'd2;
               end else if (enter_ph == 3'd2) begin
                  scl_in = 1'b1; seg_units = 8'd5;
               end else if (enter_ph == 3'd3) begin
                  scl_in = 1'b0; seg_units = 8'd5;
               end else if (enter_ph == 3'd4) begin
                  seg_units = 8'd2;
               end else if (enter_ph == 3'd5) begin
                  sda_in = 1'b1; seg_units = 8'd2;
               end else if (enter_ph == 3'd6) begin
                  scl_in = 1'b1; seg_units = ack_units;
               end else begin
                  scl_in = 1'b0; seg_units = 8'd2;
               end
            end
            default: begin
               if (enter_ph == 3'd1) begin
                  sda_in = 1'b1; seg_units = 8'd1;
               end else if (enter_ph == 3'd2) begin
                  scl_in = 1'b0; seg_units = 8'd5;
               end else if (enter_ph == 3'd3) begin
                  scl_in = 1'b1; seg_units = 8'd2;
               end else if (enter_ph == 3'd4) begin
                  seg_units = 8'd2;
               end else begin
                  scl_in = 1'b0; seg_units = 8'd2;
               end
            end
         endcase
         unit_in = seg_units - 8'd1;
         tick_in = tick_reload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_ff       <= '0;
         shift_ff     <= '0;
         tick_ff      <= '0;
         unit_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         cmd_ff       <= CMD_NONE;
         rx_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            tick_ff  <= tick_in;
            unit_ff  <= unit_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            ack_ff   <= ack_in;
            cmd_ff   <= cmd_in;
            rx_ff    <= rx_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         done_ff <= done_in;
         busy_ff <= (phase_in != PH_IDLE);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.scl_level   = scl_ff;
   assign rsp_chan.sda_release = sda_ff;
   assign rsp_chan.busy_res    = busy_ff;
   assign rsp_chan.done_res    = done_ff;
   assign rsp_chan.rx_byte     = rx_ff;
   assign rsp_chan.nack_seen   = ack_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> !busy_ff)
      else $error("done beat still reports busy");

   a_bit_bound: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= 4'd8)
      else $error("bit index past eight");

   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == CMD_START || cmd_ff == CMD_STOP || cmd_ff == CMD_ACK) |-> phase_ff <= 3'd4)
      else $error("short waveform ran past its last segment");

endmodule

// File: sv/i2c_master_bit_engine_top.sv
// A request beat goes into the front queue, then into the response register.
// Throughput: one beat per cycle if responses are taken; one step per beat.
// Each beat is one bus timing tick; SCL/SDA segments last units * unit_ticks beats.
// Reset (synchronous, active high): bus idle with SCL and SDA released, queue empty,
// unit_ticks 48, ack_wait_units 200, rx_byte and nack_seen cleared.
// ----------------------------------------------------------------------------
// I2C master bit engine top
// Front queue decodes commands; the engine drives the SCL/SDA waveforms.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top #(
   parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   i2cm_req_if.sink                        req_chan,
   i2cm_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import i2cm_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     head_valid;
   item_type head_item;
   logic     head_pop;

   // Register writes: take the low bits of the write data for the narrower register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_UNIT_TICKS: cfg_in.unit_ticks     = csr_wdata;
            CSR_ACK_WAIT:   cfg_in.ack_wait_units = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_ticks     <= UNIT_TICKS_RESET;
         cfg_ff.ack_wait_units <= ACK_WAIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept beats, decode the action and buffer them
   i2cm_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   // Back: advance the waveform one tick per beat and hold the response beat
   i2cm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Feeds bus timing ticks, some carrying commands, through the request channel.
// A beat-accurate engine model predicts every response beat, and the monitor
// checks SCL/SDA levels, status, read data and ACK status field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import i2cm_pkg::*;

   localparam int unsigned RANDOM_BEATS  = 210;   // engine-busy beats in the random part
   localparam int unsigned CHUNK_BEATS   = 200;   // beats between timing changes
   localparam int unsigned SETTLE_CYCLES = 4;     // padding once every beat and response is through
   localparam int unsigned REPORT_LIMIT  = 40;
   localparam logic [2:0]  ACT_RSVD_LO   = 3'd6;  // action codes with no meaning
   localparam logic [2:0]  ACT_RSVD_HI   = 3'd7;

   // How the sampled SDA wire level is filled in while a command runs
   typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_type;

   typedef struct {
      logic [2:0] action;
      logic [7:0] tx;
      logic       nack;
      logic       sda;
   } tick_type;

   typedef struct packed {
      logic       scl;
      logic       sda_rel;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       nack;
   } bus_view_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic                  csr_index = CSR_UNIT_TICKS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   i2cm_req_if req_chan();
   i2cm_rsp_if rsp_chan();

   i2c_master_bit_engine_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Stimulus and scoreboard
   tick_type     pending_ticks[$];
   bus_view_type expected_levels[$];
   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned busy_beats     = 0;
   int unsigned mismatch_count = 0;
   int unsigned beats_checked  = 0;
   int unsigned csr_writes     = 0;
   int unsigned done_pulses    = 0;
   int unsigned nack_samples   = 0;
   int unsigned cmd_started [0:7];

   // Engine model: timing registers and sequencer state
   logic [9:0] cfg_unit = UNIT_TICKS_RESET;
   logic [7:0] cfg_ackw = ACK_WAIT_RESET;
   logic [3:0] seg_q    = 4'(PH_IDLE);
   logic [3:0] bit_q    = '0;
   logic [7:0] shreg_q  = '0;
   logic [9:0] tick_cnt = '0;
   logic [7:0] unit_cnt = '0;
   logic       scl_q    = 1'b1;
   logic       sda_q    = 1'b1;
   logic       ack_q    = 1'b0;
   logic [7:0] rx_q     = '0;
   cmd_type    cur_cmd  = CMD_NONE;

   // A zero in either timing register counts as one
   function automatic logic [9:0] unit_len();
      return (cfg_unit == '0) ? 10'd1 : cfg_unit;
   endfunction

   function automatic logic [7:0] ack_len();
      return (cfg_ackw == '0) ? 8'd1 : cfg_ackw;
   endfunction

   // Load the levels and the length of one waveform segment
   function automatic void seg_enter(logic [3:0] seg);
      logic [7:0] units;
      units = 8'd1;
      seg_q = seg;
      case (cur_cmd)
         CMD_START: begin
            if (seg == 1) begin sda_q = 1'b1; units = 8'd1; end
            else if (seg == 2) begin scl_q = 1'b1; units = 8'd5; end
            else if (seg == 3) begin sda_q = 1'b0; units = 8'd5; end
            else begin scl_q = 1'b0; units = 8'd2; end
         end
         CMD_STOP: begin
            if (seg == 1) begin scl_q = 1'b0; sda_q = 1'b0; units = 8'd1; end
            else if (seg == 2) begin scl_q = 1'b1; units = 8'd5; end
            else begin sda_q = 1'b1; units = 8'd5; end
         end
         CMD_ACK: begin
            if (seg == 1) begin scl_q = 1'b0; sda_q = shreg_q[0]; units = 8'd3; end
            else if (seg == 2) begin scl_q = 1'b1; units = 8'd5; end
            else begin scl_q = 1'b0; units = 8'd2; end
         end
         CMD_WRITE: begin
            if (seg == 1) begin
               scl_q = 1'b0;
               sda_q = ((shreg_q & MSB_MASK) != '0);
               units = 8'd2;
            end
            else if (seg == 2) begin scl_q = 1'b1; units = 8'd5; end
            else if (seg == 3) begin scl_q = 1'b0; units = 8'd5; end
            else if (seg == 4) units = 8'd2;
            else if (seg == 5) begin sda_q = 1'b1; units = 8'd2; end
            else if (seg == 6) begin scl_q = 1'b1; units = ack_len(); end
            else begin scl_q = 1'b0; units = 8'd2; end
         end
         default: begin
            if (seg == 1) begin sda_q = 1'b1; units = 8'd1; end
            else if (seg == 2) begin scl_q = 1'b0; units = 8'd5; end
            else if (seg == 3) begin scl_q = 1'b1; units = 8'd2; end
            else if (seg == 4) units = 8'd2;
            else begin scl_q = 1'b0; units = 8'd2; end
         end
      endcase
      unit_cnt = units - 8'd1;
      tick_cnt = unit_len() - 10'd1;
   endfunction

   // Close the running segment; returns 1 when the command is over
   function automatic bit seg_finish(logic sda);
      logic [3:0] last;
      if (cur_cmd == CMD_WRITE && seg_q == 3) begin
         shreg_q = shreg_q << 1;
         bit_q   = bit_q + 4'd1;
         seg_enter((bit_q < 8) ? 4'd1 : 4'd4);
         return 1'b0;
      end
      if (cur_cmd == CMD_WRITE && seg_q == 6) begin
         ack_q = sda;
         if (sda)
            nack_samples++;
      end
      if (cur_cmd == CMD_READ && seg_q == 3)
         shreg_q = {shreg_q[6:0], sda};
      if (cur_cmd == CMD_READ && seg_q == 4) begin
         bit_q = bit_q + 4'd1;
         if (bit_q < 8) begin
            seg_enter(4'd1);
         end else begin
            rx_q = shreg_q;
            seg_enter(4'd5);
         end
         return 1'b0;
      end
      case (cur_cmd)
         CMD_START: last = 4'd4;
         CMD_WRITE: last = 4'd7;
         CMD_READ:  last = 4'd5;
         default:   last = 4'd3;
      endcase
      if (seg_q >= last) begin
         seg_q = 4'(PH_IDLE);
         return 1'b1;
      end
      seg_enter(seg_q + 4'd1);
      return 1'b0;
   endfunction

   // Advance the engine model by one tick and give the levels it shows after it
   function automatic bus_view_type engine_tick(logic [2:0] action, logic [7:0] tx,
                                                logic nack, logic sda);
      bus_view_type view;
      logic         done;
      done = 1'b0;
      if (seg_q == 4'(PH_IDLE)) begin
         if (action >= CMD_START && action <= CMD_ACK) begin
            cur_cmd = cmd_type'(action);
            cmd_started[action]++;
            bit_q = '0;
            if (cur_cmd == CMD_WRITE)
               shreg_q = tx;
            else if (cur_cmd == CMD_ACK)
               shreg_q = {7'd0, nack};
            else
               shreg_q = '0;
            seg_enter(4'(PH_FIRST));
         end
      end else if (tick_cnt != '0) begin
         tick_cnt = tick_cnt - 10'd1;
      end else if (unit_cnt != '0) begin
         unit_cnt = unit_cnt - 8'd1;
         tick_cnt = unit_len() - 10'd1;
      end else begin
         done = seg_finish(sda);
      end
      if (done)
         done_pulses++;
      view.scl     = scl_q;
      view.sda_rel = sda_q;
      view.busy    = (seg_q != 4'(PH_IDLE));
      view.done    = done;
      view.rx      = rx_q;
      view.nack    = ack_q;
      return view;
   endfunction

   // Ticks from command acceptance up to and including its done tick
   function automatic int unsigned cmd_ticks(cmd_type cmd);
      int unsigned units;
      case (cmd)
         CMD_START: units = 13;
         CMD_STOP:  units = 11;
         CMD_ACK:   units = 10;
         CMD_WRITE: units = 102 + ack_len();
         default:   units = 82;
      endcase
      return units * unit_len();
   endfunction

   function automatic logic pick_sda(sda_mode_type mode);
      case (mode)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         default:  return 1'($urandom);
      endcase
   endfunction

   function automatic void push_tick(logic [2:0] act, logic [7:0] tx, logic nack, logic sda);
      tick_type beat;
      beat.action = act;
      beat.tx     = tx;
      beat.nack   = nack;
      beat.sda    = sda;
      pending_ticks.push_back(beat);
   endfunction

   // While busy, commands are dropped; throw some in, most often on the done tick
   function automatic logic [2:0] busy_action(bit done_tick);
      if ($urandom_range(99) < (done_tick ? 25 : 5))
         return 3'($urandom_range(7));
      return CMD_NONE;
   endfunction

   // Queue one command plus exactly enough ticks to carry it through done
   task automatic issue(cmd_type cmd, logic [7:0] tx, logic nack, sda_mode_type mode);
      int unsigned len;
      len = cmd_ticks(cmd);
      push_tick(cmd, tx, nack, pick_sda(mode));
      for (int unsigned i = 1; i <= len; i++)
         push_tick(busy_action(i == len), 8'($urandom), 1'($urandom), pick_sda(mode));
      busy_beats += len + 1;
   endtask

   // Idle ticks between commands: no action or a meaningless code
   task automatic gap();
      logic [2:0] act;
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(2))
            0:       act = CMD_NONE;
            1:       act = ACT_RSVD_LO;
            default: act = ACT_RSVD_HI;
         endcase
         push_tick(act, 8'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   // Hold the generator until every beat is out, every response is back and
   // the engine model is idle; pad with empty ticks if a command still runs
   task automatic settle();
      forever begin
         while (pending_ticks.size() != 0 || req_chan.valid || expected_levels.size() != 0)
            @(negedge clock);
         if (seg_q == 4'(PH_IDLE))
            break;
         push_tick(CMD_NONE, 8'd0, 1'b0, 1'($urandom));
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_UNIT_TICKS)
         cfg_unit = value;
      else
         cfg_ackw = value[7:0];
      csr_writes++;
      @(negedge clock);
   endtask

   // Short units keep the random part compact; now and then a zero or a 2
   task automatic random_config();
      logic [9:0] unit;
      logic [7:0] wait_units;
      unit       = ($urandom_range(9) == 0) ? 10'd0 :
                   (($urandom_range(3) == 0) ? 10'd2 : 10'd1);
      wait_units = ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom_range(1, 6));
      write_csr(CSR_UNIT_TICKS, unit);
      write_csr(CSR_ACK_WAIT, {2'b00, wait_units});
   endtask

   // Mostly well-formed transfers: start, address, data phase, stop.
   // The rest are loose commands in any order (stop with no start and so on).
   task automatic run_transfer();
      logic [7:0]  addr;
      int unsigned n_ops;
      if ($urandom_range(99) < 85) begin
         addr  = 8'($urandom);
         n_ops = $urandom_range(1, 2);
         issue(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM);
         gap();
         issue(CMD_WRITE, addr, 1'($urandom), SDA_RANDOM);
         gap();
         for (int unsigned i = 0; i < n_ops; i++) begin
            if (addr[0]) begin
               issue(CMD_READ, 8'($urandom), 1'($urandom), SDA_RANDOM);
               gap();
               // NACK the last byte of a read, ACK the others
               issue(CMD_ACK, 8'($urandom), (i == n_ops - 1), SDA_RANDOM);
            end else begin
               issue(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM);
            end
            gap();
         end
         issue(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM);
         gap();
      end else begin
         repeat ($urandom_range(1, 3)) begin
            issue(cmd_type'($urandom_range(CMD_START, CMD_ACK)), 8'($urandom),
                  1'($urandom), SDA_RANDOM);
            gap();
         end
      end
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         if (mismatch_count < REPORT_LIMIT)
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Clock; start every channel input at a known level
   initial begin
      req_chan.valid    = 1'b0;
      req_chan.action   = CMD_NONE;
      req_chan.tx_byte  = '0;
      req_chan.nack_bit = 1'b0;
      req_chan.sda_line = 1'b1;
      rsp_chan.ready    = 1'b0;
      forever #2 clock = ~clock;
   end

   // Reset held from the start and released once
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Request driver: predict each accepted beat, then offer the next one
   always @(posedge clock) begin : drive_req
      tick_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_levels.push_back(engine_tick(req_chan.action, req_chan.tx_byte,
                                                  req_chan.nack_bit, req_chan.sda_line));
         // Advance only when the slot is free; otherwise hold the current beat
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_ticks.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.action   <= nxt.action;
               req_chan.tx_byte  <= nxt.tx;
               req_chan.nack_bit <= nxt.nack;
               req_chan.sda_line <= nxt.sda;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response sink: stall at the current rate
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitor: check each response beat against the oldest prediction
   always @(posedge clock) begin : check_rsp
      bus_view_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_levels.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $error("response beat arrived with no prediction pending");
            mismatch_count++;
         end else begin
            want = expected_levels.pop_front();
            compare_field("scl_level", want.scl, rsp_chan.scl_level);
            compare_field("sda_release", want.sda_rel, rsp_chan.sda_release);
            compare_field("busy_res", want.busy, rsp_chan.busy_res);
            compare_field("done_res", want.done, rsp_chan.done_res);
            compare_field("rx_byte", want.rx, rsp_chan.rx_byte);
            compare_field("nack_seen", want.nack, rsp_chan.nack_seen);
            beats_checked++;
         end
      end
   end

   // Stimulus sequence
   initial begin : run_test
      int unsigned phase_goal;
      int unsigned chunk_goal;
      foreach (cmd_started[i])
         cmd_started[i] = 0;
      while (reset)
         @(negedge clock);
      @(negedge clock);

      // Sender idles now and then, receiver stalls more than half the time
      send_idle_pct = 11;
      rsp_stall_pct = 57;

      // Reset timing: one acknowledge bit at 48 ticks per unit
      issue(CMD_ACK, 8'h00, 1'b0, SDA_RANDOM);
      settle();

      // One tick per unit with the reset ACK wait of 200 units; slave ACKs
      write_csr(CSR_UNIT_TICKS, 10'd1);
      issue(CMD_WRITE, 8'h00, 1'b0, SDA_LOW);     // all-zero byte
      settle();

      // Zero in both timing registers runs as one
      write_csr(CSR_UNIT_TICKS, '0);
      write_csr(CSR_ACK_WAIT, '0);
      // Meaningless actions on an idle engine must be dropped
      push_tick(CMD_NONE, 8'hFF, 1'b1, 1'b0);
      push_tick(ACT_RSVD_LO, 8'hFF, 1'b1, 1'b1);
      push_tick(ACT_RSVD_HI, 8'h00, 1'b0, 1'b0);
      issue(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      issue(CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH);    // all-ones byte, slave NACKs
      issue(CMD_READ, 8'h00, 1'b0, SDA_HIGH);     // reads back 0xFF
      issue(CMD_ACK, 8'h00, 1'b0, SDA_RANDOM);
      issue(CMD_READ, 8'hFF, 1'b1, SDA_LOW);      // reads back 0x00
      issue(CMD_ACK, 8'hFF, 1'b1, SDA_RANDOM);
      issue(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
      settle();

      // Random transfers in three rounds of handshake pressure
      for (int unsigned round = 0; round < 3; round++) begin
         case (round)
            0: begin send_idle_pct = 11; rsp_stall_pct = 57; end
            1: begin send_idle_pct = 57; rsp_stall_pct = 11; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         phase_goal = busy_beats + RANDOM_BEATS / 3;
         while (busy_beats < phase_goal) begin
            // Drain fully before touching timing; this is also the sender pause
            settle();
            random_config();
            chunk_goal = busy_beats + CHUNK_BEATS;
            while (busy_beats < chunk_goal && busy_beats < phase_goal)
               run_transfer();
         end
      end
      settle();

      $display("Run covered %0d response beats, %0d register writes; commands start %0d,",
               beats_checked, csr_writes, cmd_started[CMD_START]);
      $display("  stop %0d, write %0d, read %0d, ack %0d; %0d done pulses, %0d NACK samples",
               cmd_started[CMD_STOP], cmd_started[CMD_WRITE], cmd_started[CMD_READ],
               cmd_started[CMD_ACK], done_pulses, nack_samples);
      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #4000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

// File: files.f
sv/i2cm_pkg.sv
sv/i2cm_if.sv
sv/i2cm_front.sv
sv/i2cm_engine.sv
sv/i2c_master_bit_engine_top.sv
tb/tb_top.sv
